[hdl/cldq_pkg.sv]
`default_nettype none

package cldq_pkg;

   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;

   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DISPLAY   = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FOUND    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] entry_value;
      logic                     last_result;
   } res_type;

endpackage

`default_nettype wire

[hdl/cldq_store.sv]
`default_nettype none

module cldq_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [ADDR_W-1:0]                 wr_addr,
   input  wire logic signed [cldq_pkg::DATA_W-1:0] wr_data,
   input  wire logic                              rd_en,
   input  wire logic [ADDR_W-1:0]                 rd_addr,
   output      logic signed [cldq_pkg::DATA_W-1:0] rd_data
);

   logic signed [cldq_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [cldq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/cldq_ctrl.sv]
`default_nettype none

module cldq_ctrl #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [cldq_pkg::MODE_W-1:0]         req_mode,
   input  wire logic signed [cldq_pkg::DATA_W-1:0]  req_item_value,
   output      logic                                res_valid,
   input  wire logic                                res_take,
   output      cldq_pkg::res_type                   res,
   output      logic                                wr_en,
   output      logic [$clog2(CAPACITY)-1:0]         wr_addr,
   output      logic signed [cldq_pkg::DATA_W-1:0]  wr_data,
   output      logic                                rd_en,
   output      logic [$clog2(CAPACITY)-1:0]         rd_addr,
   input  wire logic signed [cldq_pkg::DATA_W-1:0]  rd_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PW    = (CNT_W > cldq_pkg::POS_W) ? CNT_W : cldq_pkg::POS_W;
   localparam logic [IDX_W:0]   CAP_X   = (IDX_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CAPACITY - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SINGLE = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [IDX_W-1:0]                    front_ff, front_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [IDX_W-1:0]                    k_ff, k_in;
   logic                                search_ff, search_in;
   logic signed [cldq_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [cldq_pkg::STATUS_W-1:0]       status_ff, status_in;

   logic             accept;
   logic             full;
   logic             empty;
   logic             last;
   logic             match;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] k_next;
   logic [PW-1:0]    pos_wide;

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= CAP_X) begin
         sum = sum - CAP_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CAP_CNT);
   assign empty     = (count_ff == '0);
   assign last      = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);
   assign match     = (rd_data == value_ff);
   assign front_dec = (front_ff == '0) ? IDX_TOP : (front_ff - IDX_W'(1));
   assign k_next    = k_ff + IDX_W'(1);
   assign pos_wide  = PW'(k_ff) + PW'(1);
   assign wr_data   = req_item_value;

   always_comb begin
      state_in   = state_ff;
      front_in   = front_ff;
      count_in   = count_ff;
      k_in       = k_ff;
      search_in  = search_ff;
      value_in   = value_ff;
      status_in  = status_ff;
      res_valid  = 1'b0;
      res.status      = status_ff;
      res.position    = '0;
      res.entry_value = '0;
      res.last_result = 1'b1;
      wr_en      = 1'b0;
      wr_addr    = front_dec;
      rd_en      = 1'b0;
      rd_addr    = ring_add(front_ff, k_next);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in  = req_item_value;
               search_in = (req_mode == cldq_pkg::MODE_SEARCH);
               unique case (req_mode)
                  cldq_pkg::MODE_INS_FRONT: begin
                     state_in = ST_SINGLE;
                     if (full) begin
                        status_in = cldq_pkg::STATUS_FULL;
                     end else begin
                        status_in = cldq_pkg::STATUS_OK;
                        wr_en     = 1'b1;
                        wr_addr   = front_dec;
                        front_in  = front_dec;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  cldq_pkg::MODE_INS_BACK: begin
                     state_in = ST_SINGLE;
                     if (full) begin
                        status_in = cldq_pkg::STATUS_FULL;
                     end else begin
                        status_in = cldq_pkg::STATUS_OK;
                        wr_en     = 1'b1;
                        wr_addr   = ring_add(front_ff, count_ff[IDX_W-1:0]);
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  cldq_pkg::MODE_DEL_FRONT, cldq_pkg::MODE_DEL_BACK: begin
                     state_in = ST_SINGLE;
                     if (empty) begin
                        status_in = cldq_pkg::STATUS_EMPTY;
                     end else begin
                        status_in = cldq_pkg::STATUS_OK;
                        count_in  = count_ff - CNT_W'(1);
                        if (count_ff == CNT_W'(1)) begin
                           front_in = '0;
                        end else if (req_mode == cldq_pkg::MODE_DEL_FRONT) begin
                           front_in = ring_add(front_ff, IDX_W'(1));
                        end
                     end
                  end
                  cldq_pkg::MODE_SEARCH, cldq_pkg::MODE_DISPLAY: begin
                     if (empty) begin
                        status_in = cldq_pkg::STATUS_EMPTY;
                        state_in  = ST_SINGLE;
                     end else begin
                        k_in     = '0;
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SINGLE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (search_ff) begin
               if (match) begin
                  res_valid    = 1'b1;
                  res.status   = cldq_pkg::STATUS_FOUND;
                  res.position = pos_wide[cldq_pkg::POS_W-1:0];
                  if (res_take) begin
                     state_in = ST_IDLE;
                  end
               end else if (last) begin
                  res_valid  = 1'b1;
                  res.status = cldq_pkg::STATUS_NOTFOUND;
                  if (res_take) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  k_in  = k_next;
                  rd_en = 1'b1;
               end
            end else begin
               res_valid       = 1'b1;
               res.status      = cldq_pkg::STATUS_OK;
               res.entry_value = rd_data;
               res.last_result = last;
               if (res_take) begin
                  if (last) begin
                     state_in = ST_IDLE;
                  end else begin
                     k_in  = k_next;
                     rd_en = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      search_ff <= search_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

[hdl/circular_list_deque_search_top.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  mode, item_value
// rsp_      out        rsp_valid / rsp_ready  status, position, entry_value, last_result
//
// Insert and delete hold their one result word until the output register is free to take it.
// Search reads entries in order from the front until a match or the last entry, and display
// gives one word per cycle while rsp_ready takes each; the store's single read port sets this.
// A new request can be taken as soon as the last word of an item is in the output register.
// Reset clears the front index and the entry count; the store contents are not cleared.
// While the output register holds an untaken word, the scan holds any word or result it has ready.

module circular_list_deque_search_top #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [cldq_pkg::MODE_W-1:0]         req_mode,
   input  wire logic signed [cldq_pkg::DATA_W-1:0]  req_item_value,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [cldq_pkg::STATUS_W-1:0]       rsp_status,
   output      logic [cldq_pkg::POS_W-1:0]          rsp_position,
   output      logic signed [cldq_pkg::DATA_W-1:0]  rsp_entry_value,
   output      logic                                rsp_last_result
);

   localparam int IDX_W = $clog2(CAPACITY);

   logic                               res_valid;
   logic                               res_take;
   cldq_pkg::res_type                  res;
   logic                               wr_en;
   logic [IDX_W-1:0]                   wr_addr;
   logic signed [cldq_pkg::DATA_W-1:0] wr_data;
   logic                               rd_en;
   logic [IDX_W-1:0]                   rd_addr;
   logic signed [cldq_pkg::DATA_W-1:0] rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   cldq_pkg::res_type rsp_data_ff;

   cldq_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_item_value(req_item_value),
      .res_valid     (res_valid),
      .res_take      (res_take),
      .res           (res),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   cldq_store #(
      .DEPTH (CAPACITY),
      .ADDR_W(IDX_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_position    = rsp_data_ff.position;
   assign rsp_entry_value = rsp_data_ff.entry_value;
   assign rsp_last_result = rsp_data_ff.last_result;

endmodule

`default_nettype wire
